// File: rtl/nndr_pkg.sv
`timescale 1ns / 1ps

package nndr_pkg;

   // field widths
   localparam int PIX_W    = 8;
   localparam int IDX_W    = 16;
   localparam int SUM_W    = 26;
   localparam int ACC_W    = 27;
   localparam int RATIO_W  = 30;
   localparam int STATUS_W = 2;

   // defaults for the top level parameters
   localparam int DEF_MAX_VECTORS = 65536;
   localparam int DEF_MAX_DIM     = 1024;

   // largest square of a pixel difference
   localparam int PIX_SQ_MAX = 65025;

   // quotient of match * 2^32 / nearest and its square root
   localparam int FRAC_W  = 32;
   localparam int QUO_W   = SUM_W + FRAC_W;
   localparam int ROOT_W  = QUO_W / 2;
   localparam int SQREM_W = ROOT_W + 2;
   localparam int STEP_W  = 6;

   localparam logic [RATIO_W-1:0] RATIO_SAT = {RATIO_W{1'b1}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_ZERO_NEAREST = 2'd1,
      STATUS_NO_MATCH     = 2'd2
   } status_type;

   // summary of one finished pass, handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0] nearest;
      logic [SUM_W-1:0] match;
      logic             match_seen;
   } pass_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_SQRT,
      BACK_DONE
   } back_state_type;

endpackage

// File: rtl/nndr_if.sv
`timescale 1ns / 1ps

// pixel pair channel
interface nndr_req_if
   import nndr_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] data_pixel;
   logic [PIX_W-1:0] query_pixel;
   logic             last_in_vector;
   logic             last_vector;

   modport source (output valid, data_pixel, query_pixel, last_in_vector, last_vector,
                   input ready);
   modport sink   (input valid, data_pixel, query_pixel, last_in_vector, last_vector,
                   output ready);
endinterface

// result channel
interface nndr_rsp_if
   import nndr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [RATIO_W-1:0]  ratio_q16;
   logic [SUM_W-1:0]    nearest_sq_dist;
   logic [SUM_W-1:0]    match_sq_dist;
   logic [STATUS_W-1:0] status;

   modport source (output valid, ratio_q16, nearest_sq_dist, match_sq_dist, status,
                   input ready);
   modport sink   (input valid, ratio_q16, nearest_sq_dist, match_sq_dist, status,
                   output ready);
endinterface

// File: rtl/nearest_neighbor_distance_ratio.sv
`timescale 1ns / 1ps

// pixel pair beats are taken one per cycle while the pass queue has room
// result valid after the last beat of a pass through pop, 58 divide steps, 29 root steps
//   and result load, or pop and result load only when no match or zero nearest
// the back end handles one pass at a time; the 4-entry queue holds finished passes
//   meanwhile, and the front stalls only when it is full
// synchronous active-high reset clears match_index, pass state, queue and result valid

module nearest_neighbor_distance_ratio
   import nndr_pkg::*;
#(
   parameter int MAX_VECTORS = DEF_MAX_VECTORS,
   parameter int MAX_DIM     = DEF_MAX_DIM
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_wr_data,
   nndr_req_if.sink         req_bus,
   nndr_rsp_if.source       rsp_bus
);

   localparam int Q_DEPTH = 4;

   pass_type push_data, pop_data;
   logic     q_push, q_pop, q_full, q_empty;

   // accumulate and classify pixel beats
   nndr_front #(
      .MAX_VECTORS (MAX_VECTORS),
      .MAX_DIM     (MAX_DIM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (push_data)
   );

   // finished passes waiting for the back end
   nndr_fifo #(
      .WIDTH (($bits(pass_type))),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // divide, square root and result register
   nndr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (pop_data),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: rtl/nndr_front.sv
`timescale 1ns / 1ps

module nndr_front
   import nndr_pkg::*;
#(
   parameter int MAX_VECTORS = DEF_MAX_VECTORS,
   parameter int MAX_DIM     = DEF_MAX_DIM
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_wr_data,
   nndr_req_if.sink         req_bus,
   input  logic             q_full,
   output logic             q_push,
   output pass_type         q_data
);

   localparam int CNT_W = (MAX_VECTORS > 2) ? $clog2(MAX_VECTORS) : 1;
   localparam logic [ACC_W-1:0] SUM_CAP = ACC_W'(MAX_DIM * PIX_SQ_MAX);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_VECTORS - 1);

   logic [IDX_W-1:0] match_index_ff;
   logic [ACC_W-1:0] running_ff, running_in;
   logic [ACC_W-1:0] nearest_ff, nearest_in;
   logic [SUM_W-1:0] match_ff, match_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             seen_ff, seen_in;

   logic             accept;
   logic [PIX_W-1:0] diff;
   logic [2*PIX_W-1:0] diff_sq;
   logic [ACC_W-1:0] sum_raw;
   logic [ACC_W-1:0] sum_sat;
   logic [ACC_W-1:0] nearest_upd;
   logic             hit;
   logic [SUM_W-1:0] match_upd;
   logic             seen_upd;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;

   // squared difference and saturating accumulate
   always_comb begin
      diff    = (req_bus.data_pixel > req_bus.query_pixel)
              ? req_bus.data_pixel - req_bus.query_pixel
              : req_bus.query_pixel - req_bus.data_pixel;
      diff_sq = diff * diff;
      sum_raw = running_ff + ACC_W'(diff_sq);
      sum_sat = (sum_raw > SUM_CAP) ? SUM_CAP : sum_raw;
   end

   // end of vector: nearest and match update
   always_comb begin
      nearest_upd = (sum_sat < nearest_ff) ? sum_sat : nearest_ff;
      hit         = !seen_ff && (IDX_W'(count_ff) == match_index_ff);
      match_upd   = hit ? sum_sat[SUM_W-1:0] : match_ff;
      seen_upd    = seen_ff || hit;
   end

   // next pass state
   always_comb begin
      running_in = running_ff;
      nearest_in = nearest_ff;
      match_in   = match_ff;
      count_in   = count_ff;
      seen_in    = seen_ff;
      q_push     = 1'b0;
      if (accept) begin
         if (!req_bus.last_in_vector) begin
            running_in = sum_sat;
         end else if (req_bus.last_vector) begin
            q_push     = 1'b1;
            running_in = '0;
            nearest_in = '1;
            match_in   = '0;
            count_in   = '0;
            seen_in    = 1'b0;
         end else begin
            running_in = '0;
            nearest_in = nearest_upd;
            match_in   = match_upd;
            count_in   = (count_ff == CNT_LAST) ? '0 : count_ff + 1'b1;
            seen_in    = seen_upd;
         end
      end
   end

   assign q_data.nearest    = nearest_upd[SUM_W-1:0];
   assign q_data.match      = match_upd;
   assign q_data.match_seen = seen_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_index_ff <= '0;
         running_ff     <= '0;
         nearest_ff     <= '1;
         match_ff       <= '0;
         count_ff       <= '0;
         seen_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            match_index_ff <= csr_wr_data;
         end
         running_ff <= running_in;
         nearest_ff <= nearest_in;
         match_ff   <= match_in;
         count_ff   <= count_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

// File: rtl/nndr_fifo.sv
`timescale 1ns / 1ps

module nndr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/nndr_back.sv
`timescale 1ns / 1ps

module nndr_back
   import nndr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  pass_type  q_data,
   output logic      q_pop,
   nndr_rsp_if.source rsp_bus
);

   back_state_type state_ff, state_in;

   pass_type            job_ff;
   logic [QUO_W-1:0]    num_ff;
   logic [SUM_W-1:0]    rem_ff;
   logic [SQREM_W-1:0]  sq_rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [RATIO_W-1:0]  ratio_ff;
   status_type          status_ff;

   logic                rsp_valid_ff;
   logic [RATIO_W-1:0]  rsp_ratio_ff;
   logic [SUM_W-1:0]    rsp_nearest_ff;
   logic [SUM_W-1:0]    rsp_match_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic                out_free;
   logic                load_out;

   // one restoring divide step
   logic [SUM_W:0]      div_trial;
   logic                div_ge;
   logic [SUM_W:0]      div_diff;

   // one square root step
   logic [SQREM_W-1:0]  sq_shift;
   logic [SQREM_W-1:0]  sq_trial;
   logic                sq_ge;
   logic [ROOT_W-1:0]   root_next;

   always_comb begin
      div_trial = {rem_ff, num_ff[QUO_W-1]};
      div_ge    = (div_trial >= {1'b0, job_ff.nearest});
      div_diff  = div_trial - {1'b0, job_ff.nearest};
      sq_shift  = {sq_rem_ff[SQREM_W-3:0], num_ff[QUO_W-1 -: 2]};
      sq_trial  = {root_ff, 2'b01};
      sq_ge     = (sq_shift >= sq_trial);
      root_next = {root_ff[ROOT_W-2:0], sq_ge};
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               if (!q_data.match_seen || q_data.nearest == '0) begin
                  state_in = BACK_DONE;
               end else begin
                  state_in = BACK_DIV;
               end
            end
         end
         BACK_DIV: begin
            if (step_ff == '0) begin
               state_in = BACK_SQRT;
            end
         end
         BACK_SQRT: begin
            if (step_ff == '0) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BACK_IDLE: q_pop    = !q_empty;
         BACK_DONE: load_out = out_free;
         default: begin
            q_pop    = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   // datapath of the shared divide and root unit
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BACK_IDLE: begin
            job_ff  <= q_data;
            num_ff  <= {q_data.match, {FRAC_W{1'b0}}};
            rem_ff  <= '0;
            step_ff <= STEP_W'(QUO_W - 1);
            if (!q_data.match_seen) begin
               status_ff <= STATUS_NO_MATCH;
               ratio_ff  <= '0;
            end else if (q_data.nearest == '0) begin
               status_ff <= STATUS_ZERO_NEAREST;
               ratio_ff  <= RATIO_SAT;
            end else begin
               status_ff <= STATUS_OK;
               ratio_ff  <= '0;
            end
         end
         BACK_DIV: begin
            rem_ff <= div_ge ? div_diff[SUM_W-1:0] : div_trial[SUM_W-1:0];
            num_ff <= {num_ff[QUO_W-2:0], div_ge};
            if (step_ff == '0) begin
               step_ff   <= STEP_W'(ROOT_W - 1);
               sq_rem_ff <= '0;
               root_ff   <= '0;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
         BACK_SQRT: begin
            sq_rem_ff <= sq_ge ? sq_shift - sq_trial : sq_shift;
            root_ff   <= root_next;
            num_ff    <= {num_ff[QUO_W-3:0], 2'b00};
            step_ff   <= step_ff - 1'b1;
            if (step_ff == '0) begin
               ratio_ff <= RATIO_W'(root_next);
            end
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ratio_ff   <= ratio_ff;
         rsp_nearest_ff <= job_ff.nearest;
         rsp_match_ff   <= job_ff.match_seen ? job_ff.match : '0;
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.ratio_q16       = rsp_ratio_ff;
   assign rsp_bus.nearest_sq_dist = rsp_nearest_ff;
   assign rsp_bus.match_sq_dist   = rsp_match_ff;
   assign rsp_bus.status          = rsp_status_ff;

endmodule
